### design/ffr_pkg.sv
// Shared types and constants for the fragment frame reassembler.
// Used by ffr_store and fragment_frame_reassembler_core; no dependencies.
package ffr_pkg;

	// Field widths of the stream beats.
	localparam int PKT_W    = 16;
	localparam int BIDX_W   = 4;
	localparam int BCNT_W   = 5;
	localparam int OFFSET_W = 11;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 12;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Width of the generation tag kept with every stored byte.
	localparam int EPOCH_W  = 8;

	localparam logic [OP_W-1:0] OP_BLOCK_BYTE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE    = 2'd2;
	localparam logic [OP_W-1:0] OP_RESET      = 2'd3;

	localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;

	// One access to the byte store, issued for an accepted beat.
	typedef struct packed {
		logic                clear;  // invalidate every stored byte
		logic                wr_en;
		logic                rd_en;
		logic [OFFSET_W-1:0] addr;
		logic [BYTE_W-1:0]   data;
	} store_req_t;

endpackage

### design/ffr_store.sv
// Tagged byte store of the fragment frame reassembler: one synchronous memory
// of data bytes with a generation tag each, plus the wipe sweep. Uses ffr_pkg.
module ffr_store #(
	parameter int DEPTH = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffr_pkg::store_req_t         req,
	output logic                        busy,
	output logic [ffr_pkg::BYTE_W-1:0]  rd_byte
);
	import ffr_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WORD_W = EPOCH_W + BYTE_W;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

	logic [WORD_W-1:0]  mem [DEPTH];
	logic [WORD_W-1:0]  rd_word_q;
	logic [EPOCH_W-1:0] rd_epoch_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [EPOCH_W-1:0] epoch_next;
	logic               sweep_q;
	logic [ADDR_W-1:0]  sweep_addr_q;
	logic               skip_q;
	logic [ADDR_W-1:0]  skip_addr_q;
	logic [ADDR_W-1:0]  addr;
	logic               wrap;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [WORD_W-1:0]  wdata;

	assign addr = req.addr[ADDR_W-1:0];
	assign wrap = req.clear && (epoch_q == EPOCH_LAST);

	always_comb begin
		epoch_next = epoch_q;
		if (req.clear) begin
			epoch_next = wrap ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
		end
	end

	// The sweep resets every tag to zero, which no live generation uses. A byte
	// written by the beat that started the sweep already carries the new tag and
	// is stepped over.
	always_comb begin
		we    = 1'b0;
		waddr = addr;
		wdata = {epoch_next, req.data};
		if (sweep_q) begin
			we    = !(skip_q && (skip_addr_q == sweep_addr_q));
			waddr = sweep_addr_q;
			wdata = '0;
		end else if (req.wr_en) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.rd_en) begin
			rd_word_q  <= mem[addr];
			rd_epoch_q <= epoch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= EPOCH_FIRST;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			skip_q       <= 1'b0;
			skip_addr_q  <= '0;
		end else begin
			epoch_q <= epoch_next;
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
				if (sweep_addr_q == ADDR_W'(DEPTH - 1)) begin
					sweep_q <= 1'b0;
				end
			end else if (wrap) begin
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
				skip_q       <= req.wr_en;
				skip_addr_q  <= addr;
			end
		end
	end

	assign busy    = sweep_q;
	assign rd_byte = (rd_word_q[WORD_W-1:BYTE_W] == rd_epoch_q) ?
		rd_word_q[BYTE_W-1:0] : '0;

endmodule

### design/fragment_frame_reassembler_core.sv
// Fragment frame reassembler: reassembles one frame from numbered blocks.
// Depends on ffr_pkg and ffr_store.
//
// Input beats arrive on the s_ channel, one per cycle while s_tready is high:
// s_tuser carries the operation (block byte, read stored byte, release frame,
// reset), s_tlast marks the last byte of a block and s_tdata the remaining
// fields. Every input beat yields exactly one result beat on the m_ channel,
// in order: m_tuser carries the drop status, m_tlast flags a completed frame
// and m_tdata the read byte and the current frame length.
// A result passes through the synchronous read of the byte store and then
// the output register before it appears on the m_ channel.
// Sustained throughput is one beat per cycle outside a sweep and stall; the
// single write and single read of the byte store per beat set that figure.
// Dropping a frame only bumps a generation tag. After reset, and again
// after every 255th frame clear, s_tready stays low while a sweep resets
// all min(FRAME_BYTES, 2048) tags.
// When the receiver stalls, one result waits in the output register and one
// in the read stage; outside a sweep, s_tready falls only when both are held.
module fragment_frame_reassembler_core #(
	parameter int MAX_BLOCKS  = 16,
	parameter int FRAME_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// packet_number[15:0], block_index[19:16], block_count[24:20],
	// byte_offset[35:25], data_byte[43:36], frame_bytes[55:44]
	input  logic [55:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	// block_end
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], length_out[19:8]
	output logic [23:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	// frame_complete
	output logic        m_tlast
);
	import ffr_pkg::*;

	localparam int STORE_DEPTH = (FRAME_BYTES < 2 ** OFFSET_W) ? FRAME_BYTES : 2 ** OFFSET_W;
	localparam int CMP_W       = 18;

	logic [PKT_W-1:0]    pn;
	logic [BIDX_W-1:0]   bidx;
	logic [BCNT_W-1:0]   bcnt;
	logic [OFFSET_W-1:0] offs;
	logic [BYTE_W-1:0]   dbyte;
	logic [LEN_W-1:0]    flen;
	logic [OP_W-1:0]     op;

	assign pn    = s_tdata[15:0];
	assign bidx  = s_tdata[19:16];
	assign bcnt  = s_tdata[24:20];
	assign offs  = s_tdata[35:25];
	assign dbyte = s_tdata[43:36];
	assign flen  = s_tdata[55:44];
	assign op    = s_tuser;

	logic                  have_q;
	logic [PKT_W-1:0]      cur_pkt_q;
	logic [MAX_BLOCKS-1:0] marks_q;
	logic [LEN_W-1:0]      len_q;

	logic                  valid_s1;
	logic [STATUS_W-1:0]   status_s1;
	logic                  complete_s1;
	logic                  rd_s1;
	logic [LEN_W-1:0]      len_s1;

	logic                  m_tvalid_q;
	logic [23:0]           m_tdata_q;
	logic [1:0]            m_tuser_q;
	logic                  m_tlast_q;

	logic                  store_busy;
	logic [BYTE_W-1:0]     rd_byte;
	store_req_t            req;

	logic                  advance_s1;
	logic                  accept;

	logic                  have_d;
	logic [PKT_W-1:0]      cur_pkt_d;
	logic [MAX_BLOCKS-1:0] marks_d;
	logic [LEN_W-1:0]      len_d;
	logic [STATUS_W-1:0]   status_d;
	logic                  complete_d;
	logic                  rd_d;

	logic                  in_range;
	logic [MAX_BLOCKS-1:0] mark_bit;
	logic [MAX_BLOCKS-1:0] full_mask;
	logic [MAX_BLOCKS-1:0] marks_base;
	logic [MAX_BLOCKS-1:0] marks_set;
	logic [CMP_W-1:0]      len_sat;
	logic                  take;

	assign advance_s1 = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready   = !store_busy && (!valid_s1 || advance_s1);
	assign accept     = s_tvalid && s_tready;

	assign in_range = {{(CMP_W - OFFSET_W){1'b0}}, offs} < CMP_W'(FRAME_BYTES);
	assign len_sat  = ({{(CMP_W - LEN_W){1'b0}}, flen} > CMP_W'(FRAME_BYTES)) ?
		CMP_W'(FRAME_BYTES) : {{(CMP_W - LEN_W){1'b0}}, flen};

	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			mark_bit[i]  = ({2'b00, bidx} == 6'(i));
			full_mask[i] = (6'(i) < {1'b0, bcnt});
		end
	end

	// Decode of one input beat against the frame state registers.
	always_comb begin
		have_d     = have_q;
		cur_pkt_d  = cur_pkt_q;
		marks_d    = marks_q;
		len_d      = len_q;
		status_d   = ST_ACCEPTED;
		complete_d = 1'b0;
		rd_d       = 1'b0;
		req        = '0;
		req.addr   = offs;
		req.data   = dbyte;
		marks_base = marks_q;
		marks_set  = marks_q;
		take       = 1'b1;
		case (op)
			OP_BLOCK_BYTE: begin
				if (!have_q) begin
					have_d    = 1'b1;
					cur_pkt_d = pn;
				end else if (pn == cur_pkt_q) begin
					if ((marks_q & mark_bit) != '0) begin
						status_d = ST_DUPLICATE;
						take     = 1'b0;
					end
				end else if (pn > cur_pkt_q) begin
					// A newer packet discards whatever was gathered so far.
					req.clear  = 1'b1;
					cur_pkt_d  = pn;
					marks_base = '0;
				end else begin
					status_d = ST_STALE;
					take     = 1'b0;
				end
				marks_set = marks_base | mark_bit;
				if (take) begin
					req.wr_en = in_range;
					len_d     = len_sat[LEN_W-1:0];
					marks_d   = s_tlast ? marks_set : marks_base;
					complete_d = s_tlast && ({1'b0, bcnt} <= 6'(MAX_BLOCKS)) &&
						(marks_set == full_mask);
				end
			end
			OP_READ_BYTE: begin
				req.rd_en = in_range;
				rd_d      = in_range;
			end
			OP_RELEASE: begin
				have_d    = 1'b1;
				cur_pkt_d = have_q ? cur_pkt_q + PKT_W'(1) : '0;
				marks_d   = '0;
				req.clear = 1'b1;
			end
			default: begin
				have_d    = 1'b0;
				marks_d   = '0;
				req.clear = 1'b1;
			end
		endcase
		if (!accept) begin
			req = '0;
		end
	end

	ffr_store #(
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.busy    (store_busy),
		.rd_byte (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			cur_pkt_q  <= '0;
			marks_q    <= '0;
			len_q      <= '0;
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				have_q    <= have_d;
				cur_pkt_q <= cur_pkt_d;
				marks_q   <= marks_d;
				len_q     <= len_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s1) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= status_d;
			complete_s1 <= complete_d;
			rd_s1       <= rd_d;
			len_s1      <= len_d;
		end
		if (advance_s1) begin
			m_tdata_q <= {4'b0000, len_s1, rd_s1 ? rd_byte : {BYTE_W{1'b0}}};
			m_tuser_q <= status_s1;
			m_tlast_q <= complete_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
